>>> hdl/tet4_pkg.sv
// Shared types, codes and the multiply program for the tetrahedron strain core.
// Used by tet4_ctrl, tet4_dp and the top level; depends on nothing else.
package tet4_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int NUM_OPS         = 48;

    // operand file: edges, gradients (cofactors), displacement differences
    localparam int SEL_G  = 9;
    localparam int SEL_DU = 18;

    // accumulator destinations: gradients 0..8, determinant, six numerators
    localparam int DEST_DET = 9;
    localparam int DEST_NUM = 10;

    localparam logic [1:0] LAST_NODE = 2'd3;

    typedef struct packed {
        logic [4:0] a_sel;
        logic [4:0] b_sel;
        logic       neg;
        logic       first;
        logic       last;
        logic [3:0] dest;
    } op_t;

    typedef op_t [NUM_OPS-1:0] op_rom_t;

    // Sequence of multiply-accumulate steps: cross products, determinant, numerators
    function automatic op_rom_t build_rom();
        op_rom_t rom;
        int r, c, t, p, q, m, s, w, i, pa, pb, a, b;
        rom = '0;
        for (int n = 0; n < NUM_OPS; n++) begin
            if (n < 18) begin
                r = n / 6;
                c = (n % 6) / 2;
                t = n % 2;
                p = (r + 1) % 3;
                q = (r + 2) % 3;
                if (t == 0) begin
                    a = p * 3 + (c + 1) % 3;
                    b = q * 3 + (c + 2) % 3;
                end else begin
                    a = p * 3 + (c + 2) % 3;
                    b = q * 3 + (c + 1) % 3;
                end
                rom[n].neg   = (t == 1);
                rom[n].first = (t == 0);
                rom[n].last  = (t == 1);
                rom[n].dest  = 4'(r * 3 + c);
            end else if (n < 21) begin
                m = n - 18;
                a = SEL_G + m;
                b = m;
                rom[n].neg   = 1'b0;
                rom[n].first = (m == 0);
                rom[n].last  = (m == 2);
                rom[n].dest  = 4'(DEST_DET);
            end else if (n < 30) begin
                m = n - 21;
                s = m / 3;
                i = m % 3;
                a = SEL_G + i * 3 + s;
                b = SEL_DU + i * 3 + s;
                rom[n].neg   = 1'b0;
                rom[n].first = (i == 0);
                rom[n].last  = (i == 2);
                rom[n].dest  = 4'(DEST_NUM + s);
            end else begin
                m  = n - 30;
                s  = m / 6;
                w  = m % 6;
                i  = w / 2;
                t  = w % 2;
                pa = (s == 0) ? 1 : 2;
                pb = (s == 1) ? 1 : 0;
                if (t == 0) begin
                    a = SEL_G + i * 3 + pa;
                    b = SEL_DU + i * 3 + pb;
                end else begin
                    a = SEL_G + i * 3 + pb;
                    b = SEL_DU + i * 3 + pa;
                end
                rom[n].neg   = 1'b0;
                rom[n].first = (w == 0);
                rom[n].last  = (w == 5);
                rom[n].dest  = 4'(DEST_NUM + 3 + s);
            end
            rom[n].a_sel = 5'(a);
            rom[n].b_sel = 5'(b);
        end
        return rom;
    endfunction

    localparam op_rom_t OP_ROM = build_rom();

    typedef struct packed {
        logic       store;
        logic       calc_edge;
        logic [4:0] rd_sel;
        logic       load_a;
        logic       clr_acc;
        logic       load_b;
        logic       mul_step;
        logic       mul_msb;
        logic       neg;
        logic       wr_en;
        logic [3:0] wr_dest;
        logic       div_load;
        logic       div_step;
        logic       div_wr;
        logic [2:0] div_idx;
        logic       zero_res;
        logic       load_out;
    } cmd_t;

    typedef struct packed {
        logic det_zero;
        logic out_free;
    } status_t;

endpackage

>>> hdl/tet4_ctrl.sv
// Sequencer for the tetrahedron strain core: walks the multiply program,
// then, unless the determinant is zero, the six divisions. Depends on tet4_pkg.
module tet4_ctrl #(
    parameter int VALUE_WIDTH = tet4_pkg::VALUE_WIDTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic [1:0]        s_node,
    output logic              s_ready,
    input  logic              cfg_we,
    input  logic [0:0]        cfg_wdata,
    input  tet4_pkg::status_t status,
    output tet4_pkg::cmd_t    cmd
);

    localparam int EW   = VALUE_WIDTH + 1;
    localparam int ACCW = 3 * EW + 4;
    localparam int FB   = VALUE_WIDTH - 8;
    localparam int TW   = ACCW + FB + 2;
    localparam int CW   = $clog2(TW + 1);
    localparam int PCW  = $clog2(tet4_pkg::NUM_OPS);

    typedef enum logic [10:0] {
        ST_IDLE = 11'b00000000001,
        ST_EDGE = 11'b00000000010,
        ST_LDA  = 11'b00000000100,
        ST_LDB  = 11'b00000001000,
        ST_RUN  = 11'b00000010000,
        ST_WB   = 11'b00000100000,
        ST_CHK  = 11'b00001000000,
        ST_DLD  = 11'b00010000000,
        ST_DRUN = 11'b00100000000,
        ST_DWB  = 11'b01000000000,
        ST_OUT  = 11'b10000000000
    } state_t;

    state_t           state_reg, state_next;
    logic [PCW-1:0]   pc_reg, pc_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [2:0]       k_reg, k_next;
    logic             active_reg;
    logic             accept;
    tet4_pkg::op_t    op;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign op      = tet4_pkg::OP_ROM[pc_reg];

    // next state and commands
    always_comb begin
        state_next  = state_reg;
        pc_next     = pc_reg;
        cnt_next    = cnt_reg;
        k_next      = k_reg;
        cmd         = '0;
        cmd.store   = accept;
        cmd.neg     = op.neg;
        cmd.wr_dest = op.dest;
        cmd.div_idx = k_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && s_node == tet4_pkg::LAST_NODE && active_reg) begin
                    state_next = ST_EDGE;
                end
            end
            ST_EDGE: begin
                cmd.calc_edge = 1'b1;
                pc_next       = '0;
                state_next    = ST_LDA;
            end
            ST_LDA: begin
                cmd.rd_sel  = op.a_sel;
                cmd.load_a  = 1'b1;
                cmd.clr_acc = op.first;
                state_next  = ST_LDB;
            end
            ST_LDB: begin
                cmd.rd_sel = op.b_sel;
                cmd.load_b = 1'b1;
                cnt_next   = '0;
                state_next = ST_RUN;
            end
            ST_RUN: begin
                cmd.mul_step = 1'b1;
                cmd.mul_msb  = (cnt_reg == CW'(EW - 1));
                cnt_next     = cnt_reg + CW'(1);
                if (cmd.mul_msb) begin
                    state_next = ST_WB;
                end
            end
            ST_WB: begin
                cmd.wr_en = op.last;
                if (pc_reg == PCW'(tet4_pkg::NUM_OPS - 1)) begin
                    state_next = ST_CHK;
                end else begin
                    pc_next    = pc_reg + PCW'(1);
                    state_next = ST_LDA;
                end
            end
            ST_CHK: begin
                if (status.det_zero) begin
                    cmd.zero_res = 1'b1;
                    state_next   = ST_OUT;
                end else begin
                    k_next     = '0;
                    state_next = ST_DLD;
                end
            end
            ST_DLD: begin
                cmd.div_load = 1'b1;
                cnt_next     = '0;
                state_next   = ST_DRUN;
            end
            ST_DRUN: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + CW'(1);
                if (cnt_reg == CW'(TW - 1)) begin
                    state_next = ST_DWB;
                end
            end
            ST_DWB: begin
                cmd.div_wr = 1'b1;
                if (k_reg == 3'd5) begin
                    state_next = ST_OUT;
                end else begin
                    k_next     = k_reg + 3'd1;
                    state_next = ST_DLD;
                end
            end
            ST_OUT: begin
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            pc_reg     <= '0;
            cnt_reg    <= '0;
            k_reg      <= '0;
            active_reg <= 1'b1;
        end else begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            cnt_reg   <= cnt_next;
            k_reg     <= k_next;
            if (cfg_we) begin
                active_reg <= cfg_wdata[0];
            end
        end
    end

    a_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_node == tet4_pkg::LAST_NODE && active_reg) |=> state_reg == ST_EDGE)
        else $error("active last corner did not start the computation");
    a_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_RUN |-> cnt_reg < CW'(EW))
        else $error("multiply bit counter overran");
    a_out: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> status.out_free)
        else $error("result loaded over an untaken result");
    a_div: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DRUN |-> $past(state_reg == ST_DLD || state_reg == ST_DRUN))
        else $error("division entered without load");

endmodule

>>> hdl/tet4_dp.sv
// Datapath of the tetrahedron strain core: corner store, edge vectors,
// serial multiply-accumulate, restoring divider and output register. Depends on tet4_pkg.
module tet4_dp #(
    parameter int VALUE_WIDTH = tet4_pkg::VALUE_WIDTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [((6*VALUE_WIDTH+7)/8)*8-1:0] s_tdata,
    input  logic [1:0]           s_tuser,
    input  tet4_pkg::cmd_t       cmd,
    output tet4_pkg::status_t    status,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [((6*VALUE_WIDTH+7)/8)*8-1:0] m_tdata,
    output logic [0:0]           m_tuser
);

    localparam int V    = VALUE_WIDTH;
    localparam int EW   = V + 1;
    localparam int GW   = 2 * EW + 1;
    localparam int ACCW = 3 * EW + 4;
    localparam int FB   = V - 8;
    localparam int TW   = ACCW + FB + 2;
    localparam int RW   = ACCW + 2;

    logic [V-1:0]      coord_reg [4][3];
    logic [V-1:0]      disp_reg  [4][3];
    logic [EW-1:0]     e_reg  [9];
    logic [EW-1:0]     du_reg [9];
    logic [GW-1:0]     g_reg  [9];
    logic [ACCW-1:0]   det_reg;
    logic [ACCW-1:0]   num_reg [6];
    logic [ACCW-1:0]   a_sh_reg, acc_reg;
    logic [EW-1:0]     b_sh_reg;
    logic [TW-1:0]     t_reg;
    logic [RW-1:0]     rem_reg;
    logic [ACCW:0]     d2_reg;
    logic [V:0]        q_reg;
    logic              ovf_reg, sign_reg;
    logic [V-1:0]      res_reg [6];
    logic [V-1:0]      out_reg [6];
    logic              deg_reg, out_valid_reg;

    logic [4:0]        rel;
    logic [ACCW-1:0]   opnd, addend, nsel, nabs, dabs;
    logic              nneg, dneg, sub;
    logic [3:0]        ni;
    logic [RW-1:0]     rem_sh;
    logic              ge;
    logic              over;
    logic [V-1:0]      lim, sat;

    assign status.det_zero = (det_reg == '0);
    assign status.out_free = !out_valid_reg || m_tready;

    // operand file read, sign extended to accumulator width
    always_comb begin
        rel  = '0;
        opnd = '0;
        if (cmd.rd_sel < 5'(tet4_pkg::SEL_G)) begin
            rel  = cmd.rd_sel;
            opnd = {{(ACCW-EW){e_reg[rel[3:0]][EW-1]}}, e_reg[rel[3:0]]};
        end else if (cmd.rd_sel < 5'(tet4_pkg::SEL_DU)) begin
            rel  = cmd.rd_sel - 5'(tet4_pkg::SEL_G);
            opnd = {{(ACCW-GW){g_reg[rel[3:0]][GW-1]}}, g_reg[rel[3:0]]};
        end else begin
            rel  = cmd.rd_sel - 5'(tet4_pkg::SEL_DU);
            opnd = {{(ACCW-EW){du_reg[rel[3:0]][EW-1]}}, du_reg[rel[3:0]]};
        end
    end

    // multiply step: sign bit of the multiplier carries negative weight
    assign addend = b_sh_reg[0] ? a_sh_reg : '0;
    assign sub    = cmd.neg ^ cmd.mul_msb;
    assign ni     = cmd.wr_dest - 4'(tet4_pkg::DEST_NUM);

    // divider operands: magnitudes and quotient sign
    assign nsel = num_reg[cmd.div_idx];
    assign nneg = nsel[ACCW-1];
    assign dneg = det_reg[ACCW-1];
    assign nabs = nneg ? (~nsel + ACCW'(1)) : nsel;
    assign dabs = dneg ? (~det_reg + ACCW'(1)) : det_reg;
    assign rem_sh = {rem_reg[RW-2:0], t_reg[TW-1]};
    assign ge     = (rem_sh >= RW'(d2_reg));

    // rounding already folded in, saturate to the output range
    always_comb begin
        over = ovf_reg | q_reg[V];
        lim  = sign_reg ? (V'(1) << (V - 1)) : ((V'(1) << (V - 1)) - V'(1));
        sat  = (over || q_reg[V-1:0] > lim) ? lim : q_reg[V-1:0];
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.store) begin
            for (int k = 0; k < 3; k++) begin
                coord_reg[s_tuser][k] <= s_tdata[k*V +: V];
                disp_reg[s_tuser][k]  <= s_tdata[(k+3)*V +: V];
            end
        end
        if (cmd.calc_edge) begin
            for (int i = 0; i < 3; i++) begin
                for (int k = 0; k < 3; k++) begin
                    e_reg[i*3+k]  <= {coord_reg[i+1][k][V-1], coord_reg[i+1][k]}
                                   - {coord_reg[0][k][V-1], coord_reg[0][k]};
                    du_reg[i*3+k] <= {disp_reg[i+1][k][V-1], disp_reg[i+1][k]}
                                   - {disp_reg[0][k][V-1], disp_reg[0][k]};
                end
            end
        end
        if (cmd.load_a) begin
            a_sh_reg <= opnd;
            if (cmd.clr_acc) begin
                acc_reg <= '0;
            end
        end
        if (cmd.load_b) begin
            b_sh_reg <= opnd[EW-1:0];
        end
        if (cmd.mul_step) begin
            acc_reg  <= sub ? (acc_reg - addend) : (acc_reg + addend);
            a_sh_reg <= a_sh_reg << 1;
            b_sh_reg <= b_sh_reg >> 1;
        end
        if (cmd.wr_en) begin
            if (cmd.wr_dest < 4'(tet4_pkg::DEST_DET)) begin
                g_reg[cmd.wr_dest] <= acc_reg[GW-1:0];
            end else if (cmd.wr_dest == 4'(tet4_pkg::DEST_DET)) begin
                det_reg <= acc_reg;
            end else begin
                num_reg[ni[2:0]] <= acc_reg;
            end
        end
        if (cmd.div_load) begin
            t_reg    <= (TW'(nabs) << (FB + 1)) + TW'(dabs);
            d2_reg   <= {dabs, 1'b0};
            rem_reg  <= '0;
            q_reg    <= '0;
            ovf_reg  <= 1'b0;
            sign_reg <= nneg ^ dneg;
        end
        if (cmd.div_step) begin
            t_reg   <= t_reg << 1;
            rem_reg <= ge ? (rem_sh - RW'(d2_reg)) : rem_sh;
            q_reg   <= {q_reg[V-1:0], ge};
            ovf_reg <= ovf_reg | q_reg[V];
        end
        if (cmd.div_wr) begin
            res_reg[cmd.div_idx] <= sign_reg ? (~sat + V'(1)) : sat;
        end
        if (cmd.zero_res) begin
            for (int k = 0; k < 6; k++) begin
                res_reg[k] <= '0;
            end
        end
        if (cmd.load_out) begin
            for (int k = 0; k < 6; k++) begin
                out_reg[k] <= res_reg[k];
            end
            deg_reg <= status.det_zero;
        end
    end

    // result valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tuser[0] = deg_reg;

    always_comb begin
        m_tdata = '0;
        for (int k = 0; k < 6; k++) begin
            m_tdata[k*V +: V] = out_reg[k];
        end
    end

endmodule

>>> hdl/tet4_strain_from_displacement_core.sv
// Top level of the constant-strain tetrahedron core: strains from corner data.
// Depends on tet4_pkg, tet4_ctrl and tet4_dp.
//
// Use: send the four corners of an element on the s_ stream, one request per
// corner, corner number in s_tuser. Corners 0..2 are only stored.
// Corner 3 is stored and, with element_active set, starts the computation of
// the six engineering strains, which leave on the m_ stream as one request
// (degenerate flag in m_tuser). With element_active clear, no result is sent.
// The run time of an element is set by the bit-serial multiplier that runs the
// 48 products and the one-bit-a-step restoring divider run six times.
// A zero volume skips the divisions. s_tready is low while an element computes.
// A finished result waits in the output register; the next corners are taken
// meanwhile, and a new result waits until the receiver takes the old one.
// Reset (aresetn low, synchronous) clears the sequencer, empties the output
// and sets element_active; cfg_we writes element_active from cfg_wdata.
module tet4_strain_from_displacement_core #(
    parameter int VALUE_WIDTH = tet4_pkg::VALUE_WIDTH_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    // coord_x, coord_y, coord_z, disp_x, disp_y, disp_z
    input  logic [((6*VALUE_WIDTH+7)/8)*8-1:0] s_tdata,
    // node_index
    input  logic [1:0] s_tuser,
    input  logic       s_tvalid,
    output logic       s_tready,
    // strain_xx, strain_yy, strain_zz, shear_xy, shear_yz, shear_xz
    output logic [((6*VALUE_WIDTH+7)/8)*8-1:0] m_tdata,
    // degenerate
    output logic [0:0] m_tuser,
    output logic       m_tvalid,
    input  logic       m_tready,
    input  logic       cfg_we,
    input  logic [0:0] cfg_wdata
);

    tet4_pkg::cmd_t    cmd;
    tet4_pkg::status_t status;

    tet4_ctrl #(.VALUE_WIDTH(VALUE_WIDTH)) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_tvalid),
        .s_node    (s_tuser),
        .s_ready   (s_tready),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .status    (status),
        .cmd       (cmd)
    );

    tet4_dp #(.VALUE_WIDTH(VALUE_WIDTH)) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cmd      (cmd),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

>>> tb/sv/tet4_strain_from_displacement_core_test.sv
// Self-checking bench for the constant-strain tetrahedron core.
// Streams corner requests, predicts the strains of each element on its own
// and checks every result request. Depends on tet4_pkg and the core itself.
`timescale 1ns / 1ps

module tet4_strain_from_displacement_core_test;

    localparam int W      = 32;
    localparam int DW     = ((6 * W + 7) / 8) * 8;
    localparam int SETTLE = 3000;   // above the corner 3 latency
    localparam int WD_MAX = 20000;

    typedef logic signed [255:0] wide_t;

    typedef struct {
        logic [1:0]    node;
        logic [DW-1:0] data;
    } corner_req_t;

    typedef struct {
        logic [DW-1:0] strains;
        logic          degenerate;
    } strain_res_t;

    logic          aclk;
    logic          aresetn;
    logic [DW-1:0] s_tdata;
    logic [1:0]    s_tuser;
    logic          s_tvalid;
    logic          s_tready;
    logic [DW-1:0] m_tdata;
    logic [0:0]    m_tuser;
    logic          m_tvalid;
    logic          m_tready;
    logic          cfg_we;
    logic [0:0]    cfg_wdata;

    corner_req_t   pending_corners[$];
    strain_res_t   expected_strains[$];
    logic signed [W-1:0] pos_mirror[12];
    logic signed [W-1:0] disp_mirror[12];
    logic          active_mirror;
    logic          in_taken;
    logic          no_gaps;
    int            send_gap;
    int            recv_gap;
    int            idle_cycles;
    int            errors;

    tet4_strain_from_displacement_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 9);
        if (no_gaps || r < 6) return 0;
        if (r < 9) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // rounded quotient num/den with 24 fraction bits, saturated to 32 bits
    function automatic logic [W-1:0] strain_quotient(wide_t num, wide_t den);
        logic  neg;
        wide_t n, d, q, lim;
        neg = (num < 0) != (den < 0);
        n   = (num < 0) ? -num : num;
        d   = (den < 0) ? -den : den;
        q   = ((n <<< (W - 7)) + d) / (d <<< 1);
        lim = neg ? (wide_t'(1) <<< (W - 1)) : ((wide_t'(1) <<< (W - 1)) - 1);
        if (q > lim) q = lim;
        q = neg ? -q : q;
        return q[W-1:0];
    endfunction

    // strains of the element held in the corner mirrors
    function automatic strain_res_t element_strains();
        wide_t       e[3][3], du[3][3], g[3][3], det;
        wide_t       num[6];
        strain_res_t res;
        for (int i = 0; i < 3; i++)
            for (int k = 0; k < 3; k++) begin
                e[i][k]  = wide_t'(pos_mirror[(i + 1) * 3 + k]) - wide_t'(pos_mirror[k]);
                du[i][k] = wide_t'(disp_mirror[(i + 1) * 3 + k]) - wide_t'(disp_mirror[k]);
            end
        // cofactor rows: e1 x e2, e2 x e0, e0 x e1
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                g[r][c] = e[(r + 1) % 3][(c + 1) % 3] * e[(r + 2) % 3][(c + 2) % 3]
                        - e[(r + 1) % 3][(c + 2) % 3] * e[(r + 2) % 3][(c + 1) % 3];
        det = e[0][0] * g[0][0] + e[0][1] * g[0][1] + e[0][2] * g[0][2];
        for (int k = 0; k < 6; k++) num[k] = 0;
        for (int i = 0; i < 3; i++) begin
            num[0] += g[i][0] * du[i][0];
            num[1] += g[i][1] * du[i][1];
            num[2] += g[i][2] * du[i][2];
            num[3] += g[i][1] * du[i][0] + g[i][0] * du[i][1];
            num[4] += g[i][2] * du[i][1] + g[i][1] * du[i][2];
            num[5] += g[i][2] * du[i][0] + g[i][0] * du[i][2];
        end
        res.strains    = '0;
        res.degenerate = (det == 0);
        if (det != 0)
            for (int k = 0; k < 6; k++) res.strains[k*W +: W] = strain_quotient(num[k], det);
        return res;
    endfunction

    // drive corner requests and the result ready at the falling edge
    always @(negedge aclk) begin
        int gap;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            m_tready <= 1'b0;
            send_gap <= 0;
            recv_gap <= 0;
        end else begin
            if (!s_tvalid || in_taken) begin
                // a request taken this cycle may be followed directly
                gap = in_taken ? pick_gap() : send_gap;
                if (gap == 0 && pending_corners.size() > 0) begin
                    s_tvalid <= 1'b1;
                    s_tuser  <= pending_corners[0].node;
                    s_tdata  <= pending_corners[0].data;
                    void'(pending_corners.pop_front());
                    send_gap <= 0;
                end else begin
                    s_tvalid <= 1'b0;
                    send_gap <= (gap > 0) ? gap - 1 : 0;
                end
            end
            if (recv_gap > 0) begin
                m_tready <= 1'b0;
                recv_gap <= recv_gap - 1;
            end else begin
                m_tready <= 1'b1;
                recv_gap <= pick_gap();
            end
        end
    end

    // predict on accepted corners, check results, watch for a hang
    always @(posedge aclk) begin
        strain_res_t exp_res;
        in_taken <= aresetn && s_tvalid && s_tready;
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WD_MAX) begin
                $display("tb: failure");
                $finish;
            end
            if (s_tvalid && s_tready) begin
                for (int k = 0; k < 3; k++) begin
                    pos_mirror[s_tuser * 3 + k]  = s_tdata[k*W +: W];
                    disp_mirror[s_tuser * 3 + k] = s_tdata[(k + 3)*W +: W];
                end
                if (s_tuser == tet4_pkg::LAST_NODE && active_mirror)
                    expected_strains.push_back(element_strains());
            end
            if (m_tvalid && m_tready) begin
                if (expected_strains.size() == 0) begin
                    $display("%0t unexpected result: actual %h %b", $realtime, m_tdata, m_tuser);
                    errors++;
                end else begin
                    exp_res = expected_strains.pop_front();
                    for (int k = 0; k < 6; k++)
                        if (m_tdata[k*W +: W] !== exp_res.strains[k*W +: W]) begin
                            $display("%0t strain %0d mismatch: expected %h actual %h", $realtime,
                                     k, exp_res.strains[k*W +: W], m_tdata[k*W +: W]);
                            errors++;
                        end
                    if (m_tuser[0] !== exp_res.degenerate) begin
                        $display("%0t degenerate mismatch: expected %b actual %b", $realtime,
                                 exp_res.degenerate, m_tuser[0]);
                        errors++;
                    end
                end
            end
        end
    end

    task automatic push_corner(input logic [1:0] node,
                               input logic [W-1:0] cx, cy, cz, dx, dy, dz);
        corner_req_t req;
        req.node = node;
        req.data = {dz, dy, dx, cz, cy, cx};
        pending_corners.push_back(req);
    endtask

    // coordinate: mostly a few units, sometimes any 32-bit value
    function automatic logic [W-1:0] rand_pos();
        if ($urandom_range(0, 5) == 0) return $urandom;
        return W'($signed($urandom_range(0, 1 << 20)) - (1 << 19)) <<< 2;
    endfunction

    function automatic logic [W-1:0] rand_disp();
        if ($urandom_range(0, 5) == 0) return $urandom;
        return W'($signed($urandom_range(0, 1 << 12)) - (1 << 11));
    endfunction

    task automatic rand_corners(input int count);
        int sent;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(0, 9) < 8) begin
                for (int n = 0; n < 4; n++)
                    push_corner(2'(n), rand_pos(), rand_pos(), rand_pos(),
                                rand_disp(), rand_disp(), rand_disp());
                sent += 4;
            end else begin
                // out-of-order corners overwriting a stored element
                repeat ($urandom_range(1, 4)) begin
                    push_corner(2'($urandom_range(0, 3)), rand_pos(), rand_pos(), rand_pos(),
                                rand_disp(), rand_disp(), rand_disp());
                    sent++;
                end
            end
        end
    endtask

    // wait for every request sent and every result back, then let the core settle
    task automatic drain_and_settle();
        while (pending_corners.size() > 0 || s_tvalid || expected_strains.size() > 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_active(input logic value);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        active_mirror = value;
    endtask

    localparam logic [W-1:0] ONE  = 32'h0001_0000;
    localparam logic [W-1:0] MAXV = 32'h7fff_ffff;
    localparam logic [W-1:0] MINV = 32'h8000_0000;

    initial begin
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = '0;
        m_tready      = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        in_taken      = 1'b0;
        no_gaps       = 1'b0;
        idle_cycles   = 0;
        errors        = 0;
        active_mirror = 1'b1;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        write_active(1'b1);

        // unit tetrahedron with a small stretch and shear
        push_corner(0, 0, 0, 0, 0, 0, 0);
        push_corner(1, ONE, 0, 0, 32'h0000_0100, 0, 0);
        push_corner(2, 0, ONE, 0, 32'h0000_0080, 32'hffff_ff00, 0);
        push_corner(3, 0, 0, ONE, 0, 32'h0000_0040, 32'h0000_0200);
        // mirrored orientation: negative volume, only corners 1 and 3 change
        push_corner(1, 32'hffff_0000, 0, 0, 32'hffff_fff0, 0, 0);
        push_corner(3, 0, 0, ONE, MAXV, MINV, 32'h0000_0001);
        // zero volume: all corners at one point
        for (int n = 0; n < 4; n++) push_corner(2'(n), ONE, ONE, ONE, MAXV, MINV, n);
        // zero volume: four corners on a line
        for (int n = 0; n < 4; n++) push_corner(2'(n), n * ONE, n * ONE, n * ONE, 0, 0, ONE);
        // field extremes, strains saturating both ways
        push_corner(0, MINV, MINV, MINV, MINV, MAXV, MINV);
        push_corner(1, MAXV, MINV, MINV, MAXV, MINV, MAXV);
        push_corner(2, MINV, MAXV, MINV, MINV, MINV, MAXV);
        push_corner(3, MINV, MINV, MAXV, MAXV, MAXV, MINV);
        // tiny element with large displacements
        push_corner(0, 0, 0, 0, MINV, MINV, MINV);
        push_corner(1, 1, 0, 0, MAXV, 0, 0);
        push_corner(2, 0, 1, 0, 0, MAXV, 0);
        push_corner(3, 0, 0, 1, 0, 0, MAXV);
        drain_and_settle();

        rand_corners(300);
        drain_and_settle();

        // inactive element: corners are stored, no result comes back
        write_active(1'b0);
        rand_corners(80);
        drain_and_settle();

        write_active(1'b1);
        rand_corners(120);
        no_gaps = 1'b1;
        rand_corners(60);
        while (pending_corners.size() > 0) @(posedge aclk);
        no_gaps = 1'b0;
        rand_corners(80);
        drain_and_settle();

        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
